// ===== hw/rtl/lpg_pkg.sv =====
package lpg_pkg;

   // coordinate width of the screen (64x64 by default)
   localparam int COORD_BITS  = 6;
   localparam int COLOUR_BITS = 32;
   // error term width: covers -2*dmaj .. +2*dmin with margin
   localparam int ERR_BITS    = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0]  coord_type;
   typedef logic [COLOUR_BITS-1:0] colour_type;
   typedef logic [ERR_BITS-1:0]    err_type;

   // one line request
   typedef struct packed {
      coord_type  start_x;
      coord_type  start_y;
      coord_type  end_x;
      coord_type  end_y;
      colour_type line_colour;
   } req_type;

   // one pixel write
   typedef struct packed {
      coord_type  pixel_x;
      coord_type  pixel_y;
      colour_type pixel_colour;
      logic       last_pixel;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the request
      logic setup;   // compute deltas and initial error
      logic emit;    // write one pixel into the output register, advance walk
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;     // zero major span, valid during setup
      logic at_last;   // current pixel is the final one
      logic out_free;  // output register can take a pixel this cycle
   } status_type;

endpackage

// ===== hw/rtl/lpg_ctrl.sv =====
module lpg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lpg_pkg::status_type status,
   output lpg_pkg::cmd_type    cmd
);
   import lpg_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   // commands follow directly from state and handshakes
   always_comb begin
      cmd.load  = req_valid && ready_ff;
      cmd.setup = (state_ff == ST_SETUP);
      cmd.emit  = (state_ff == ST_WALK) && status.out_free;
   end

   assign req_ready = ready_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               state_in = ST_SETUP;
               ready_in = 1'b0;
            end
         end
         ST_SETUP: begin
            if (status.empty) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.out_free && status.at_last) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

// ===== hw/rtl/lpg_datapath.sv =====
module lpg_datapath (
   input  logic                clock,
   input  logic                reset,
   input  lpg_pkg::req_type    req_data,
   input  lpg_pkg::cmd_type    cmd,
   output lpg_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lpg_pkg::rsp_type    rsp_data
);
   import lpg_pkg::*;

   localparam int C = COORD_BITS;

   // captured request
   req_type    req_ff;

   // walk state
   coord_type  major_ff,    major_in;
   coord_type  maj_end_ff,  maj_end_in;
   coord_type  minor_ff,    minor_in;
   logic       neg_ff,      neg_in;
   logic       steep_ff,    steep_in;
   err_type    err_ff,      err_in;
   err_type    two_dmin_ff, two_dmin_in;
   err_type    two_diff_ff, two_diff_in;

   // output register
   rsp_type    rsp_ff,      rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // setup signals
   logic signed [C:0] dx, dy, dmin_s;
   coord_type         adx, ady, admin, dmaj;
   coord_type         maj0, min0, maj1, min1;
   coord_type         s_maj0, s_min0, s_maj1, s_min1;
   logic              steep, swap;
   logic              err_pos;
   logic [C:0]        major_next;

   // deltas, octant selection and endpoint ordering
   always_comb begin
      dx    = $signed({1'b0, req_ff.end_x}) - $signed({1'b0, req_ff.start_x});
      dy    = $signed({1'b0, req_ff.end_y}) - $signed({1'b0, req_ff.start_y});
      adx   = dx[C] ? C'(-dx) : C'(dx);
      ady   = dy[C] ? C'(-dy) : C'(dy);
      steep = ady > adx;
      if (steep) begin
         maj0 = req_ff.start_y; min0 = req_ff.start_x;
         maj1 = req_ff.end_y;   min1 = req_ff.end_x;
      end else begin
         maj0 = req_ff.start_x; min0 = req_ff.start_y;
         maj1 = req_ff.end_x;   min1 = req_ff.end_y;
      end
      swap = maj1 < maj0;
      if (swap) begin
         s_maj0 = maj1; s_min0 = min1; s_maj1 = maj0; s_min1 = min0;
      end else begin
         s_maj0 = maj0; s_min0 = min0; s_maj1 = maj1; s_min1 = min1;
      end
      dmaj   = s_maj1 - s_maj0;
      dmin_s = $signed({1'b0, s_min1}) - $signed({1'b0, s_min0});
      admin  = dmin_s[C] ? C'(-dmin_s) : C'(dmin_s);
   end

   // walk step and setup loading
   always_comb begin
      err_pos    = !err_ff[ERR_BITS-1] && (err_ff != '0);
      major_next = {1'b0, major_ff} + (C+1)'(1);

      major_in    = major_ff;
      maj_end_in  = maj_end_ff;
      minor_in    = minor_ff;
      neg_in      = neg_ff;
      steep_in    = steep_ff;
      err_in      = err_ff;
      two_dmin_in = two_dmin_ff;
      two_diff_in = two_diff_ff;

      if (cmd.setup) begin
         major_in    = s_maj0;
         maj_end_in  = s_maj1;
         minor_in    = s_min0;
         neg_in      = dmin_s[C];
         steep_in    = steep;
         two_dmin_in = {{(ERR_BITS-C-1){1'b0}}, admin, 1'b0};
         two_diff_in = {{(ERR_BITS-C-1){1'b0}}, admin, 1'b0}
                     - {{(ERR_BITS-C-1){1'b0}}, dmaj, 1'b0};
         err_in      = {{(ERR_BITS-C-1){1'b0}}, admin, 1'b0}
                     - {{(ERR_BITS-C){1'b0}}, dmaj};
      end else if (cmd.emit) begin
         major_in = major_next[C-1:0];
         if (err_pos) begin
            minor_in = neg_ff ? minor_ff - C'(1) : minor_ff + C'(1);
            err_in   = err_ff + two_diff_ff;
         end else begin
            err_in   = err_ff + two_dmin_ff;
         end
      end
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_in.pixel_x      = steep_ff ? minor_ff : major_ff;
         rsp_in.pixel_y      = steep_ff ? major_ff : minor_ff;
         rsp_in.pixel_colour = req_ff.line_colour;
         rsp_in.last_pixel   = status.at_last;
         rsp_valid_in        = 1'b1;
      end
   end

   // status back to the controller
   always_comb begin
      status.empty    = (s_maj0 == s_maj1);
      status.at_last  = (major_next == {1'b0, maj_end_ff});
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      major_ff    <= major_in;
      maj_end_ff  <= maj_end_in;
      minor_ff    <= minor_in;
      neg_ff      <= neg_in;
      steep_ff    <= steep_in;
      err_ff      <= err_in;
      two_dmin_ff <= two_dmin_in;
      two_diff_ff <= two_diff_in;
      rsp_ff      <= rsp_in;
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/line_pixel_generator_top.sv =====
// the setup state comes between a request transfer and its first pixel
// throughput: one pixel per cycle while the output is taken; a line of major
//   span N gives N pixels (setup state, then one walk step per pixel)
// the next request is taken once the last pixel sits in the output register
// reset: synchronous, active high; clears controller state and output valid
module line_pixel_generator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lpg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lpg_pkg::rsp_type rsp_data
);
   import lpg_pkg::*;

   cmd_type    cmd;
   status_type status;

   lpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a request transfer is followed by setup, never by a pixel
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !cmd.emit)
      else $error("pixel emitted in the cycle after a request transfer");

   // pixels only go into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("pixel emitted over a waiting result");

   // no new request while a line is still being walked
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && cmd.emit))
      else $error("request ready during walk");

   // the final pixel of a line reopens the request side
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.at_last |=> req_ready)
      else $error("request side not reopened after last pixel");

endmodule

// ===== test/line_pixel_checker.sv =====
`timescale 1ns / 1ps

module line_pixel_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  lpg_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  lpg_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_pixels
);
   import lpg_pkg::*;

   // pixel writes still owed by the block, oldest first
   rsp_type expected_pixels[$];
   int      error_total = 0;

   // walk one line the way the block should and queue every pixel write
   task automatic queue_line_pixels(input req_type line);
      int      ax, ay, bx, by;
      int      maj0, min0, maj1, min1, swap;
      int      dmaj, dmin, step, err, minor, major;
      bit      steep;
      rsp_type pix;
      ax = line.start_x;
      ay = line.start_y;
      bx = line.end_x;
      by = line.end_y;
      steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
      if (steep) begin
         maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
      end else begin
         maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
      end
      // walk along increasing major coordinate
      if (maj1 < maj0) begin
         swap = maj0; maj0 = maj1; maj1 = swap;
         swap = min0; min0 = min1; min1 = swap;
      end
      dmaj = maj1 - maj0;
      dmin = min1 - min0;
      step = 1;
      if (dmin < 0) begin
         step = -1;
         dmin = -dmin;
      end
      err = 2 * dmin - dmaj;
      minor = min0;
      // far endpoint is not drawn
      for (major = maj0; major < maj1; major++) begin
         pix.pixel_x      = coord_type'(steep ? minor : major);
         pix.pixel_y      = coord_type'(steep ? major : minor);
         pix.pixel_colour = line.line_colour;
         pix.last_pixel   = (major + 1 == maj1);
         expected_pixels.push_back(pix);
         if (err > 0) begin
            minor += step;
            err += 2 * (dmin - dmaj);
         end else begin
            err += 2 * dmin;
         end
      end
   endtask

   // watch both channels on every edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         // pixel transfer against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("unexpected pixel x=%0d y=%0d colour=%h last=%0b",
                           rsp_data.pixel_x, rsp_data.pixel_y,
                           rsp_data.pixel_colour, rsp_data.last_pixel);
            end else begin
               want = expected_pixels.pop_front();
               if (want.pixel_x !== rsp_data.pixel_x ||
                   want.pixel_y !== rsp_data.pixel_y ||
                   want.pixel_colour !== rsp_data.pixel_colour ||
                   want.last_pixel !== rsp_data.last_pixel) begin
                  error_total++;
                  if (error_total <= 10)
                     $display({"pixel mismatch: expected x=%0d y=%0d colour=%h last=%0b,",
                               " got x=%0d y=%0d colour=%h last=%0b"},
                              want.pixel_x, want.pixel_y, want.pixel_colour,
                              want.last_pixel,
                              rsp_data.pixel_x, rsp_data.pixel_y,
                              rsp_data.pixel_colour, rsp_data.last_pixel);
               end
            end
         end
         // line request transfer
         if (req_valid && req_ready)
            queue_line_pixels(req_data);
      end
      mismatch_count <= error_total;
      pending_pixels <= expected_pixels.size();
   end

endmodule

// ===== test/line_pixel_generator_top_tb.sv =====
`timescale 1ns / 1ps

module line_pixel_generator_top_tb;
   import lpg_pkg::*;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      mismatch_count;
   int      pending_pixels;

   // random idling on both sides, and long output hold-off requests
   logic    idle_on = 1'b0;
   int      stall_requests = 0;

   line_pixel_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   line_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_pixels (pending_pixels)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // offer one line request and hold it until the transfer
   task automatic send_line(input req_type line);
      while (idle_on && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= line;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait until every queued pixel has come out
   task automatic wait_drained();
      @(posedge clock);
      while (pending_pixels != 0) @(posedge clock);
   endtask

   // pixel receiver: random idling, plus long hold-offs on request
   initial begin
      int stall_served;
      int hold_left;
      stall_served = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            hold_left    = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on) begin
            rsp_ready <= ($urandom_range(99) >= 18);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // line request stimulus and verdict
   initial begin
      req_type line;
      int      kind, ox, oy, span;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines: extremes, both slopes, equal spans, coincident points
      send_line('{6'd0,  6'd0,  6'd63, 6'd0,  32'h0000_0000});
      send_line('{6'd63, 6'd63, 6'd0,  6'd63, 32'hffff_ffff});
      send_line('{6'd0,  6'd0,  6'd0,  6'd63, 32'ha5a5_a5a5});
      send_line('{6'd5,  6'd63, 6'd5,  6'd0,  32'h5a5a_5a5a});
      send_line('{6'd0,  6'd0,  6'd63, 6'd63, 32'h1234_5678});
      send_line('{6'd63, 6'd0,  6'd0,  6'd63, 32'h8765_4321});
      send_line('{6'd10, 6'd10, 6'd10, 6'd10, 32'hdead_beef});
      send_line('{6'd63, 6'd63, 6'd63, 6'd63, 32'hffff_ffff});
      send_line('{6'd0,  6'd0,  6'd1,  6'd0,  32'h0000_0001});
      send_line('{6'd0,  6'd0,  6'd1,  6'd1,  32'h8000_0000});
      send_line('{6'd1,  6'd1,  6'd0,  6'd0,  32'h7fff_ffff});
      send_line('{6'd0,  6'd0,  6'd63, 6'd20, 32'h0f0f_0f0f});
      send_line('{6'd0,  6'd40, 6'd63, 6'd5,  32'hf0f0_f0f0});
      send_line('{6'd3,  6'd0,  6'd20, 6'd63, 32'h3333_3333});
      send_line('{6'd60, 6'd2,  6'd10, 6'd63, 32'hcccc_cccc});
      send_line('{6'd32, 6'd32, 6'd33, 6'd34, 32'h5555_5555});
      send_line('{6'd42, 6'd21, 6'd21, 6'd42, 32'haaaa_aaaa});
      send_line('{6'd62, 6'd1,  6'd1,  6'd2,  32'h0001_0000});
      req_valid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);

      // random lines, mostly with idling on both sides
      idle_on <= 1'b1;
      for (int n = 0; n < 142; n++) begin
         if (n == 40) stall_requests <= stall_requests + 1;
         if (n == 80) idle_on <= 1'b0;
         if (n == 115) idle_on <= 1'b1;
         kind = $urandom_range(99);
         line.line_colour = $urandom();
         line.start_x = coord_type'($urandom_range(63));
         line.start_y = coord_type'($urandom_range(63));
         line.end_x   = coord_type'($urandom_range(63));
         line.end_y   = coord_type'($urandom_range(63));
         if (kind >= 55 && kind < 80) begin
            // short line around the start point
            ox = int'(line.start_x) + $urandom_range(8) - 4;
            oy = int'(line.start_y) + $urandom_range(8) - 4;
            line.end_x = coord_type'((ox < 0) ? 0 : (ox > 63) ? 63 : ox);
            line.end_y = coord_type'((oy < 0) ? 0 : (oy > 63) ? 63 : oy);
         end else if (kind >= 80 && kind < 87) begin
            line.end_y = line.start_y;
         end else if (kind >= 87 && kind < 94) begin
            line.end_x = line.start_x;
         end else if (kind >= 94 && kind < 98) begin
            // diagonal where it fits
            span = (line.end_x > line.start_x) ? int'(line.end_x - line.start_x)
                                               : int'(line.start_x - line.end_x);
            if (int'(line.start_y) + span <= 63)
               line.end_y = coord_type'(int'(line.start_y) + span);
            else if (int'(line.start_y) - span >= 0)
               line.end_y = coord_type'(int'(line.start_y) - span);
         end else if (kind >= 98) begin
            line.end_x = line.start_x;
            line.end_y = line.start_y;
         end
         send_line(line);
      end
      req_valid <= 1'b0;

      // drain, then let trailing pixels show up
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
